### rtl/lwm_pkg.sv
// lwm_pkg: shared constants, codes and types of the like wildcard matcher
package lwm_pkg;

   localparam int PATTERN_MAX  = 32;
   localparam int CHAR_BITS    = 8;
   localparam int LEN_BITS     = $clog2(PATTERN_MAX + 1);
   localparam int FUNC_BITS    = 2;
   localparam int CSR_IDX_BITS = 1;

   // request function codes
   localparam logic [FUNC_BITS-1:0] FUNC_APPEND  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_SUBJECT = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_FINISH  = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SINGLE_WC = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEQ_WC    = 1'b1;

   localparam logic [CHAR_BITS-1:0] SINGLE_WC_RESET = 8'd95;
   localparam logic [CHAR_BITS-1:0] SEQ_WC_RESET    = 8'd37;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                 step;
      logic                 rearm;
      logic [CHAR_BITS-1:0] symbol;
      logic [CHAR_BITS-1:0] seq_wc;
      logic [CHAR_BITS-1:0] single_wc;
   } lwm_cell_ctrl_type;

endpackage

### rtl/lwm_cell.sv
// lwm_cell: one pattern position, holds its character and active bit
module lwm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  lwm_pkg::lwm_cell_ctrl_type ctrl,
   input  logic                       home,
   input  logic                       load,
   input  logic                       in_use,
   input  logic                       carry_in,
   input  logic                       step_in,
   output logic                       closed,
   output logic                       carry_out,
   output logic                       step_out
);

   logic [lwm_pkg::CHAR_BITS-1:0] char_ff, char_in;
   logic                          act_ff, act_in;
   logic                          is_seq, is_hit;

   assign is_seq = (char_ff == ctrl.seq_wc);
   assign is_hit = (char_ff == ctrl.single_wc) || (char_ff == ctrl.symbol);

   // closure ripples through sequence wildcards from the left
   assign closed    = act_ff | carry_in;
   assign carry_out = closed & in_use & is_seq;
   assign step_out  = closed & in_use & ~is_seq & is_hit;

   always_comb begin
      if (ctrl.step) begin
         act_in = carry_out | step_in;
      end else if (ctrl.rearm) begin
         act_in = home;
      end else begin
         act_in = act_ff;
      end
      char_in = load ? ctrl.symbol : char_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= home;
      end else begin
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

endmodule

### rtl/like_wildcard_matcher.sv
// like_wildcard_matcher: sql like predicate engine built from a chain of pattern cells
//
// request channel (req_valid, req_stall, req_func, req_symbol): one beat per character.
//    append adds a pattern character, subject streams a subject character, finish asks
//    for the verdict and rearms, clear empties the pattern and the overflow flag.
// result channel (rsp_valid, rsp_stall, rsp_matched, rsp_pattern_overflow): one beat
//    for every finish beat, in order, nothing for the other functions.
// csr channel (csr_valid, csr_ready, csr_index, csr_wdata): index 0 single wildcard,
//    index 1 sequence wildcard; always ready, new codes apply from the next beat.
// throughput: one request beat per cycle while not stalled, every function alike.
//    the whole active set is updated each cycle by the row of cells, and the sequence
//    wildcard closure ripples through all cells in that cycle: the critical path.
// latency: the result beat appears the cycle after its finish beat.
// reset: pattern empty, overflow clear, wildcards back to '_' and '%', only start active.
// stall: the result register holds while rsp_stall is high; req_stall goes high only
//    while a result is held and stalled, otherwise requests flow on.
module like_wildcard_matcher (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lwm_pkg::FUNC_BITS-1:0]        req_func,
   input  logic [lwm_pkg::CHAR_BITS-1:0]        req_symbol,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_matched,
   output logic                                 rsp_pattern_overflow,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lwm_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [lwm_pkg::CHAR_BITS-1:0]        csr_wdata
);

   // wildcard registers
   logic [lwm_pkg::CHAR_BITS-1:0] single_wc_ff, single_wc_in;
   logic [lwm_pkg::CHAR_BITS-1:0] seq_wc_ff, seq_wc_in;

   // pattern length and sticky overflow
   logic [lwm_pkg::LEN_BITS-1:0]  length_ff, length_in;
   logic                          overflow_ff, overflow_in;

   // active bit of the end position, past the last cell
   logic                          end_ff, end_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_matched_ff, rsp_matched_in;
   logic                          rsp_overflow_ff, rsp_overflow_in;

   logic                          accept;
   logic                          append_beat, subject_beat, finish_beat, clear_beat;
   logic                          store_full;
   lwm_pkg::lwm_cell_ctrl_type    ctrl;

   // chain wiring
   logic [lwm_pkg::PATTERN_MAX-1:0] carry;
   logic [lwm_pkg::PATTERN_MAX-1:0] step;
   logic [lwm_pkg::PATTERN_MAX:0]   closed_pos;

   // request handshake: only a held, stalled result blocks new beats
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign append_beat  = accept && (req_func == lwm_pkg::FUNC_APPEND);
   assign subject_beat = accept && (req_func == lwm_pkg::FUNC_SUBJECT);
   assign finish_beat  = accept && (req_func == lwm_pkg::FUNC_FINISH);
   assign clear_beat   = accept && (req_func == lwm_pkg::FUNC_CLEAR);
   assign store_full   = (length_ff == lwm_pkg::LEN_BITS'(lwm_pkg::PATTERN_MAX));

   assign ctrl.step      = subject_beat;
   assign ctrl.rearm     = append_beat | finish_beat | clear_beat;
   assign ctrl.symbol    = req_symbol;
   assign ctrl.seq_wc    = seq_wc_ff;
   assign ctrl.single_wc = single_wc_ff;

   // the row of cells, position i held by cell i
   for (genvar i = 0; i < lwm_pkg::PATTERN_MAX; i++) begin : g_cell
      logic cin, sin;
      if (i == 0) begin : g_first
         assign cin = 1'b0;
         assign sin = 1'b0;
      end else begin : g_next
         assign cin = carry[i-1];
         assign sin = step[i-1];
      end
      lwm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .home      ((i == 0) ? 1'b1 : 1'b0),
         .load      (append_beat && (length_ff == lwm_pkg::LEN_BITS'(i))),
         .in_use    (lwm_pkg::LEN_BITS'(i) < length_ff),
         .carry_in  (cin),
         .step_in   (sin),
         .closed    (closed_pos[i]),
         .carry_out (carry[i]),
         .step_out  (step[i])
      );
   end

   // end position: reached by the last cell, closed through a trailing sequence wildcard
   assign closed_pos[lwm_pkg::PATTERN_MAX] = end_ff | carry[lwm_pkg::PATTERN_MAX-1];

   always_comb begin
      if (subject_beat) begin
         end_in = step[lwm_pkg::PATTERN_MAX-1];
      end else if (ctrl.rearm) begin
         end_in = 1'b0;
      end else begin
         end_in = end_ff;
      end
   end

   // pattern length and overflow
   always_comb begin
      length_in   = length_ff;
      overflow_in = overflow_ff;
      if (clear_beat) begin
         length_in   = '0;
         overflow_in = 1'b0;
      end else if (append_beat) begin
         if (store_full) begin
            overflow_in = 1'b1;
         end else begin
            length_in = length_ff + lwm_pkg::LEN_BITS'(1);
         end
      end
   end

   // wildcard registers
   assign csr_ready = 1'b1;

   always_comb begin
      single_wc_in = single_wc_ff;
      seq_wc_in    = seq_wc_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lwm_pkg::CSR_SINGLE_WC: begin
               single_wc_in = csr_wdata;
            end
            lwm_pkg::CSR_SEQ_WC: begin
               seq_wc_in = csr_wdata;
            end
            default: begin
               single_wc_in = single_wc_ff;
            end
         endcase
      end
   end

   // result register, verdict read at the end of the pattern
   always_comb begin
      rsp_matched_in  = rsp_matched_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (finish_beat) begin
         rsp_valid_in    = 1'b1;
         rsp_matched_in  = closed_pos[length_ff];
         rsp_overflow_in = overflow_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_wc_ff <= lwm_pkg::SINGLE_WC_RESET;
         seq_wc_ff    <= lwm_pkg::SEQ_WC_RESET;
         length_ff    <= '0;
         overflow_ff  <= 1'b0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         single_wc_ff <= single_wc_in;
         seq_wc_ff    <= seq_wc_in;
         length_ff    <= length_in;
         overflow_ff  <= overflow_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff  <= rsp_matched_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_overflow_ff;

   // a result beat only ever follows a finish beat
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish_beat))
      else $error("result beat without a finish beat");

   // the pattern never grows past the store
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= lwm_pkg::LEN_BITS'(lwm_pkg::PATTERN_MAX))
      else $error("pattern length beyond store");

   // clear drops the pattern and the overflow flag together
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clear_beat |=> (length_ff == '0) && !overflow_ff)
      else $error("clear did not empty the pattern");

   // overflow can only be set by an append into a full store
   a_overflow_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_ff) |-> $past(append_beat && store_full))
      else $error("overflow set without a full-store append");

endmodule
